// ===== design/stq_pkg.sv =====
// Package for the sorted timer queue: sizes, codes and state types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;
    localparam int TIMERS = 16;
    localparam int SLOT_W = 4;
    localparam int LEN_W = 5;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_ALLOC   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_ARM     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_ALLOC = 2'd0,
        RES_EXPIRY = 2'd1,
        RES_ACK = 2'd2
    } res_kind_t;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_ALLOC = 2'd1,
        ST_ARMED = 2'd2
    } slot_st_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_EXPIRE,
        FSM_ACK,
        FSM_OUT
    } fsm_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_EXEC,
        CMD_POP,
        CMD_ACK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    last;
    } stq_cmd_t;

    typedef struct packed {
        logic       head_expired;
        logic       next_expired;
        logic       out_last;
        logic [1:0] kind;
        logic [4:0] pops;
    } stq_status_t;
endpackage
`default_nettype wire

// ===== design/stq_if.sv =====
// Valid/ready channel interfaces for the timer queue's input and result items.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface stq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [31:0] delay;
    logic [3:0]  fifo_tag;
    logic [7:0]  payload;
    modport source (output valid, kind, slot, delay, fifo_tag, payload, input ready);
    modport sink (input valid, kind, slot, delay, fifo_tag, payload, output ready);
endinterface

interface stq_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [3:0] result_slot;
    logic       ok;
    logic [3:0] out_fifo_tag;
    logic [7:0] out_payload;
    logic       last;
    modport source (output valid, result_kind, result_slot, ok, out_fifo_tag,
                    out_payload, last, input ready);
    modport sink (input valid, result_kind, result_slot, ok, out_fifo_tag,
                  out_payload, last, output ready);
endinterface
`default_nettype wire

// ===== design/sorted_timer_queue_core.sv =====
// Top level of the sorted timer queue: controller plus datapath.
// Depends on stq_pkg, stq_if, stq_ctrl and stq_datapath.
`timescale 1ns / 1ps
`default_nettype none
// One item enters on the "cmd_in" channel; its results leave on "res".
// Allocate gives one answer, release and arm one acknowledge; a tick emits
// one expiry item per expired timer in deadline order (at most 16) or one
// acknowledge, with last set on the final result of the item.
// An item is taken in the idle state and executed in the execute state;
// its first result is then prepared in the expire or acknowledge state and
// shown in the output state. Each further expiry takes a pop, then
// presentation. The block handles one item at a time.
// The sorted order lives in 16 parallel cells, so insertion and the removal
// of a released or re-armed slot settle in the execute cycle.
// While the receiver stalls, the result register holds and no new item is
// taken. Reset empties the queue, frees every slot and zeroes the tick count.
// The next item is taken in the cycle after the result marked last is
// delivered.
module sorted_timer_queue_core
    import stq_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    stq_in_if.sink    cmd_in,
    stq_out_if.source res
);
    stq_cmd_t    cmd;
    stq_status_t status;

    stq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_in.valid),
        .in_ready  (cmd_in.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    stq_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (cmd_in.kind),
        .slot         (cmd_in.slot),
        .delay        (cmd_in.delay),
        .fifo_tag     (cmd_in.fifo_tag),
        .payload      (cmd_in.payload),
        .result_kind  (res.result_kind),
        .result_slot  (res.result_slot),
        .ok           (res.ok),
        .out_fifo_tag (res.out_fifo_tag),
        .out_payload  (res.out_payload),
        .last         (res.last)
    );
endmodule
`default_nettype wire

// ===== design/stq_datapath.sv =====
// Datapath of the timer queue: slot store, sorted order cells, tick counter, result register.
// Depends on stq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stq_datapath
    import stq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire stq_cmd_t    cmd,
    output stq_status_t      status,
    input  wire logic [1:0]  kind,
    input  wire logic [3:0]  slot,
    input  wire logic [31:0] delay,
    input  wire logic [3:0]  fifo_tag,
    input  wire logic [7:0]  payload,
    output logic [1:0]       result_kind,
    output logic [3:0]       result_slot,
    output logic             ok,
    output logic [3:0]       out_fifo_tag,
    output logic [7:0]       out_payload,
    output logic             last
);
    logic [1:0]  kind_reg;
    logic [3:0]  slot_reg, tag_reg;
    logic [31:0] delay_reg;
    logic [7:0]  pay_reg;
    logic [31:0] tick_reg;
    logic [4:0]  pops_reg;
    slot_st_t    st_reg [TIMERS];
    logic [31:0] dl_reg [TIMERS];
    logic [3:0]  tg_reg [TIMERS];
    logic [7:0]  by_reg [TIMERS];
    logic [SLOT_W-1:0] q_reg [TIMERS];
    logic [LEN_W-1:0]  len_reg;

    // Queue after removal of the addressed slot (when armed).
    logic [SLOT_W-1:0] qr [TIMERS];
    logic [LEN_W-1:0]  lenr;
    logic [TIMERS-1:0] hit, past_hit, later;
    logic [31:0] dnew;
    logic [SLOT_W-1:0] free_idx;
    logic free_any;
    logic [SLOT_W-1:0] head;

    always_comb
    begin
        for (int i = 0; i < TIMERS; i++)
        begin
            hit[i] = (q_reg[i] == slot_reg) && (LEN_W'(i) < len_reg);
        end
        for (int i = 0; i < TIMERS; i++)
        begin
            past_hit[i] = 1'b0;
            for (int j = 0; j < i; j++)
            begin
                if (hit[j])
                begin
                    past_hit[i] = 1'b1;
                end
            end
        end
        for (int i = 0; i < TIMERS; i++)
        begin
            if (past_hit[i] || hit[i])
            begin
                qr[i] = (i < TIMERS-1) ? q_reg[(i+1) % TIMERS] : q_reg[i];
            end
            else
            begin
                qr[i] = q_reg[i];
            end
        end
        lenr = (|hit) ? len_reg - 1'b1 : len_reg;
        dnew = tick_reg + delay_reg;
        for (int i = 0; i < TIMERS; i++)
        begin
            later[i] = (LEN_W'(i) < lenr) && !(dl_reg[qr[i]] < dnew);
        end
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TIMERS-1; i >= 0; i--)
        begin
            if (st_reg[i] == ST_FREE)
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
        head = q_reg[0];
        status.kind = kind_reg;
        status.pops = pops_reg;
        status.head_expired = (len_reg != '0) && (dl_reg[head] <= tick_reg);
        // The entry behind the head decides whether a pop is the final expiry.
        status.next_expired = (len_reg > LEN_W'(1)) && (dl_reg[q_reg[1]] <= tick_reg);
        status.out_last = last;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_LOAD)
        begin
            slot_reg <= slot;
            delay_reg <= delay;
            tag_reg <= fifo_tag;
            pay_reg <= payload;
        end
        if (cmd.op == CMD_EXEC && kind_reg == KIND_ARM)
        begin
            dl_reg[slot_reg] <= dnew;
            tg_reg[slot_reg] <= tag_reg;
            by_reg[slot_reg] <= pay_reg;
            // Insert ahead of the first equal-or-later entry.
            for (int i = 0; i < TIMERS; i++)
            begin
                if (later[i])
                begin
                    q_reg[i] <= (i == 0 || !later[(i+TIMERS-1) % TIMERS]) ? slot_reg
                                : qr[(i+TIMERS-1) % TIMERS];
                end
                else if (LEN_W'(i) == lenr)
                begin
                    q_reg[i] <= (i > 0 && later[(i+TIMERS-1) % TIMERS])
                                ? qr[(i+TIMERS-1) % TIMERS] : slot_reg;
                end
                else
                begin
                    q_reg[i] <= qr[i];
                end
            end
        end
        else if (cmd.op == CMD_EXEC && kind_reg == KIND_RELEASE)
        begin
            for (int i = 0; i < TIMERS; i++)
            begin
                q_reg[i] <= qr[i];
            end
        end
        else if (cmd.op == CMD_POP)
        begin
            for (int i = 0; i < TIMERS-1; i++)
            begin
                q_reg[i] <= q_reg[i+1];
            end
        end
        case (cmd.op)
            CMD_POP:
            begin
                result_kind  <= RES_EXPIRY;
                result_slot  <= head;
                ok           <= 1'b0;
                out_fifo_tag <= tg_reg[head];
                out_payload  <= by_reg[head];
                last         <= cmd.last;
            end
            CMD_ACK:
            begin
                result_kind  <= (kind_reg == KIND_ALLOC) ? RES_ALLOC : RES_ACK;
                result_slot  <= (kind_reg == KIND_ALLOC && free_any) ? free_idx : '0;
                ok           <= (kind_reg == KIND_ALLOC) && free_any;
                out_fifo_tag <= '0;
                out_payload  <= '0;
                last         <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_TICK;
            tick_reg <= '0;
            len_reg  <= '0;
            pops_reg <= '0;
            for (int i = 0; i < TIMERS; i++)
            begin
                st_reg[i] <= ST_FREE;
            end
        end
        else
        begin
            case (cmd.op)
                CMD_LOAD:
                begin
                    kind_reg <= kind;
                    pops_reg <= '0;
                end
                CMD_EXEC:
                begin
                    case (kind_reg)
                        KIND_TICK:    tick_reg <= tick_reg + 32'd1;
                        KIND_RELEASE:
                        begin
                            st_reg[slot_reg] <= ST_FREE;
                            len_reg <= lenr;
                        end
                        KIND_ARM:
                        begin
                            st_reg[slot_reg] <= ST_ARMED;
                            len_reg <= lenr + 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_POP:
                begin
                    st_reg[head] <= ST_ALLOC;
                    len_reg <= len_reg - 1'b1;
                    pops_reg <= pops_reg + 1'b1;
                end
                CMD_ACK:
                begin
                    if (kind_reg == KIND_ALLOC && free_any)
                    begin
                        st_reg[free_idx] <= ST_ALLOC;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/stq_ctrl.sv =====
// Controller state machine of the timer queue; sequences load, execute, expiry and output.
// Depends on stq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stq_ctrl
    import stq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire stq_status_t status,
    output stq_cmd_t         cmd
);
    fsm_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op = CMD_NONE;
        cmd.last = 1'b0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = CMD_LOAD;
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                cmd.op = CMD_EXEC;
                state_next = (status.kind == KIND_TICK) ? FSM_EXPIRE : FSM_ACK;
            end
            FSM_EXPIRE:
            begin
                if (status.head_expired && status.pops < 5'd16)
                begin
                    // The pop is final when it is the sixteenth or nothing behind it is due.
                    cmd.op = CMD_POP;
                    cmd.last = (status.pops == 5'd15) || !status.next_expired;
                    state_next = FSM_OUT;
                end
                else
                begin
                    state_next = FSM_ACK;
                end
            end
            FSM_ACK:
            begin
                cmd.op = CMD_ACK;
                cmd.last = 1'b1;
                state_next = FSM_OUT;
            end
            FSM_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = status.out_last ? FSM_IDLE : FSM_EXPIRE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== design/stq_checker.sv =====
// Port-level checker for the sorted timer queue, bound to the top level.
// Depends on stq_pkg and the top level's interface ports.
`timescale 1ns / 1ps
`default_nettype none
module stq_port_props
    import stq_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] result_kind,
    input wire logic       ok,
    input wire logic       last
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("input taken while result pending");
    a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");
    a_alloc_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind != RES_EXPIRY) |-> last)
        else $error("answer not last");
    a_ok_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ok) |-> result_kind == RES_ALLOC) else $error("ok misplaced");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(result_kind) && $stable(ok)
        && $stable(last)) else $error("result changed while stalled");
endmodule

bind sorted_timer_queue_core stq_port_props u_stq_port_props (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cmd_in.valid),
    .in_ready    (cmd_in.ready),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .result_kind (res.result_kind),
    .ok          (res.ok),
    .last        (res.last)
);
`default_nettype wire

// ===== tb/stq_tb_if.sv =====
// Note: the channel interfaces come from design/stq_if.sv; this file only
// holds the testbench-side item type used by the checker.
// Depends on stq_pkg.
`timescale 1ns / 1ps
package stq_tb_pkg;
    import stq_pkg::*;

    typedef struct {
        logic [1:0] rkind;
        logic [3:0] rslot;
        logic       ok;
        logic [3:0] tag;
        logic [7:0] pay;
        logic       last;
    } stq_result_t;
endpackage

// ===== tb/stq_checker.sv =====
// Checker for the sorted timer queue: mirrors the timer pool and sorted queue,
// predicts the results of each accepted item and compares them in order.
// Depends on stq_pkg, stq_tb_pkg and the channel interfaces.
`timescale 1ns / 1ps
module stq_checker
    import stq_pkg::*;
    import stq_tb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    stq_in_if          cmd_mon,
    stq_out_if         res_mon,
    output int         fail_count,
    output int         pending,
    output int         expiry_seen
);
    logic [31:0] now_ticks;
    slot_st_t    st [TIMERS];
    logic [31:0] due [TIMERS];
    logic [3:0]  tag_of [TIMERS];
    logic [7:0]  pay_of [TIMERS];
    int          order [$];
    stq_result_t expected_results [$];

    function automatic void add_result(logic [1:0] k, logic [3:0] s, logic o,
                                       logic [3:0] t, logic [7:0] p, logic l);
        stq_result_t r;
        r.rkind = k; r.rslot = s; r.ok = o; r.tag = t; r.pay = p; r.last = l;
        expected_results.push_back(r);
    endfunction

    function automatic void drop_slot(int s);
        foreach (order[i])
            if (order[i] == s)
            begin
                order.delete(i);
                return;
            end
    endfunction

    function automatic void predict_item(logic [1:0] k, logic [3:0] s, logic [31:0] d,
                                         logic [3:0] t, logic [7:0] p);
        int pos;
        int n;
        int h;
        n = 0;
        case (k)
            KIND_ALLOC:
            begin
                for (int i = 0; i < TIMERS; i++)
                    if (st[i] == ST_FREE)
                    begin
                        st[i] = ST_ALLOC;
                        add_result(RES_ALLOC, 4'(i), 1'b1, 4'd0, 8'd0, 1'b1);
                        return;
                    end
                add_result(RES_ALLOC, 4'd0, 1'b0, 4'd0, 8'd0, 1'b1);
            end
            KIND_RELEASE:
            begin
                if (st[s] == ST_ARMED)
                    drop_slot(int'(s));
                st[s] = ST_FREE;
                add_result(RES_ACK, 4'd0, 1'b0, 4'd0, 8'd0, 1'b1);
            end
            KIND_ARM:
            begin
                if (st[s] == ST_ARMED)
                    drop_slot(int'(s));
                tag_of[s] = t;
                pay_of[s] = p;
                due[s] = now_ticks + d;
                st[s] = ST_ARMED;
                pos = 0;
                while (pos < order.size() && due[order[pos]] < due[s])
                    pos++;
                order.insert(pos, int'(s));
                add_result(RES_ACK, 4'd0, 1'b0, 4'd0, 8'd0, 1'b1);
            end
            default:
            begin
                now_ticks = now_ticks + 32'd1;
                while (n < 16 && order.size() > 0 && due[order[0]] <= now_ticks)
                begin
                    h = order.pop_front();
                    st[h] = ST_ALLOC;
                    add_result(RES_EXPIRY, 4'(h), 1'b0, tag_of[h], pay_of[h], 1'b0);
                    n++;
                end
                if (n == 0)
                    add_result(RES_ACK, 4'd0, 1'b0, 4'd0, 8'd0, 1'b1);
                else
                    expected_results[$].last = 1'b1;
            end
        endcase
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        stq_result_t e;
        if (!rst_n)
        begin
            now_ticks = '0;
            order.delete();
            expected_results.delete();
            for (int i = 0; i < TIMERS; i++)
                st[i] = ST_FREE;
            fail_count <= 0;
            expiry_seen <= 0;
        end
        else
        begin
            // Results first: an item accepted now cannot produce a result in
            // the same edge, so the order of the two steps is safe.
            if (res_mon.valid && res_mon.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d slot=%0d", $time,
                             res_mon.result_kind, res_mon.result_slot);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e.rkind === RES_EXPIRY)
                        expiry_seen <= expiry_seen + 1;
                    if (res_mon.result_kind !== e.rkind || res_mon.result_slot !== e.rslot
                        || res_mon.ok !== e.ok || res_mon.out_fifo_tag !== e.tag
                        || res_mon.out_payload !== e.pay || res_mon.last !== e.last)
                    begin
                        $display("%0t: mismatch expected k%0d s%0d ok%0d t%0d p%0d l%0d",
                                 $time, e.rkind, e.rslot, e.ok, e.tag, e.pay, e.last);
                        $display("%0t:          actual   k%0d s%0d ok%0d t%0d p%0d l%0d",
                                 $time, res_mon.result_kind, res_mon.result_slot,
                                 res_mon.ok, res_mon.out_fifo_tag, res_mon.out_payload,
                                 res_mon.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
                predict_item(cmd_mon.kind, cmd_mon.slot, cmd_mon.delay,
                             cmd_mon.fifo_tag, cmd_mon.payload);
        end
    end
endmodule

// ===== tb/sorted_timer_queue_core_tb.sv =====
// Testbench top for sorted_timer_queue_core: clock, reset, stimulus, receiver
// stalls and verdict. Depends on stq_pkg, stq_if, stq_tb_pkg and stq_checker.
`timescale 1ns / 1ps
module sorted_timer_queue_core_tb;
    import stq_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   expiry_seen;
    int   quiet_cycles = 0;
    int   sent = 0;
    bit   calm = 1'b0;       // no idling on either side in the last stretch
    bit   hold_off = 1'b0;   // long receiver stall while the sender keeps going

    stq_in_if  cmd_ch ();
    stq_out_if res_ch ();

    always #6 clk = ~clk;

    sorted_timer_queue_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_in (cmd_ch.sink),
        .res    (res_ch.source)
    );

    stq_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_mon     (cmd_ch),
        .res_mon     (res_ch),
        .fail_count  (fail_count),
        .pending     (pending),
        .expiry_seen (expiry_seen)
    );

    // The driver and receiver only ever drive from the clock edge, so the
    // checker samples values that were settled before that edge.
    initial
    begin
        cmd_ch.valid = 1'b0;
        cmd_ch.kind = '0;
        cmd_ch.slot = '0;
        cmd_ch.delay = '0;
        cmd_ch.fifo_tag = '0;
        cmd_ch.payload = '0;
        res_ch.ready = 1'b0;
    end

    // Sends one item and waits for its acceptance. A random idle burst may come
    // first, unless the run has entered its calm final stretch.
    task automatic send_item(kind_t k, logic [3:0] s, logic [31:0] d,
                             logic [3:0] t, logic [7:0] p);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind <= k;
        cmd_ch.slot <= s;
        cmd_ch.delay <= d;
        cmd_ch.fifo_tag <= t;
        cmd_ch.payload <= p;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    // Random timer content with every kind of item, ticks most often. Most
    // delays are short so timers actually expire; a few use the full range.
    task automatic random_item();
        int pick;
        logic [31:0] d;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       d = $urandom();
            1:       d = 32'hffff_ffff - $urandom_range(0, 3);
            default: d = $urandom_range(0, 6);
        endcase
        if (pick < 40)
            send_item(KIND_TICK, 4'($urandom()), $urandom(), 4'($urandom()),
                      8'($urandom()));
        else if (pick < 55)
            send_item(KIND_ALLOC, 4'($urandom()), $urandom(), 4'($urandom()),
                      8'($urandom()));
        else if (pick < 65)
            send_item(KIND_RELEASE, 4'($urandom()), $urandom(), 4'($urandom()),
                      8'($urandom()));
        else
            send_item(KIND_ARM, 4'($urandom()), d, 4'($urandom()), 8'($urandom()));
    endtask

    // Receiver: random stall bursts, or one long hold-off when asked.
    always @(posedge clk)
    begin
        int stall;
        if (rst_n)
        begin
            if (hold_off)
                res_ch.ready <= 1'b0;
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 5);
                res_ch.ready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_n
            || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: fill the pool, fail an allocation, exercise every
        // kind, field extremes, re-arming and releasing a free slot.
        for (int i = 0; i < 16; i++)
            send_item(KIND_ALLOC, 4'h0, 32'h0, 4'h0, 8'h00);
        send_item(KIND_ALLOC, 4'hf, 32'hffff_ffff, 4'hf, 8'hff);  // pool exhausted
        send_item(KIND_RELEASE, 4'hf, 32'h0, 4'h0, 8'h00);
        send_item(KIND_RELEASE, 4'hf, 32'h0, 4'h0, 8'h00);       // already free
        send_item(KIND_ARM, 4'hf, 32'h0, 4'hf, 8'hff);           // free slot armed anyway
        send_item(KIND_ARM, 4'h3, 32'hffff_ffff, 4'h5, 8'ha5);   // deadline at top of range
        send_item(KIND_ARM, 4'h4, 32'h2, 4'h0, 8'h00);
        send_item(KIND_ARM, 4'h4, 32'h1, 4'h1, 8'h01);           // re-arm armed slot
        send_item(KIND_TICK, 4'h0, 32'h0, 4'h0, 8'h00);
        send_item(KIND_TICK, 4'hf, 32'hffff_ffff, 4'hf, 8'hff);

        // More than sixteen can never be armed, so arm all sixteen at once on
        // the same deadline, hold the receiver off, and let one tick flush them.
        for (int i = 0; i < 16; i++)
            send_item(KIND_ARM, 4'(i), 32'h1, 4'(i), 8'hf0 | 8'(i));
        hold_off = 1'b1;
        fork
            begin
                send_item(KIND_TICK, 4'h0, 32'h0, 4'h0, 8'h00);
                send_item(KIND_ALLOC, 4'h0, 32'h0, 4'h0, 8'h00);
            end
        join_none
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
        wait fork;

        while (sent < 220)
        begin
            if (sent >= 190)
                calm = 1'b1;
            random_item();
        end
        cmd_ch.valid <= 1'b0;

        while (pending > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d items; %0d timer expiries checked, including a full-pool flush.",
                 sent, expiry_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
